// File: hw/rtl/yfr_pkg.sv
// Shared constants, types and helpers for the YUV 4:2:0 frame rotator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package yfr_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int PIX_W       = 8;
   localparam int DIM_W       = $clog2(MAX_WIDTH) + 1;
   localparam int BANK_SIZE   = MAX_WIDTH * MAX_HEIGHT
                                + 2 * ((MAX_WIDTH / 2) * (MAX_HEIGHT / 2));
   localparam int STORE_DEPTH = 2 * BANK_SIZE;
   localparam int POS_W       = $clog2(BANK_SIZE);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int OFF_W       = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int QUO_W       = $clog2(MAX_WIDTH);
   localparam int COL_W       = $clog2(MAX_HEIGHT);

   localparam logic [ADDR_W-1:0] BANK_OFFSET = ADDR_W'(BANK_SIZE);
   localparam logic [DIM_W-1:0]  MAX_W_DIM   = DIM_W'(MAX_WIDTH);
   localparam logic [DIM_W-1:0]  MAX_H_DIM   = DIM_W'(MAX_HEIGHT);
   localparam logic [DIM_W-1:0]  MIN_DIM     = DIM_W'(2);

   localparam logic [1:0] PLANE_Y = 2'd0;
   localparam logic [1:0] PLANE_U = 2'd1;
   localparam logic [1:0] PLANE_V = 2'd2;

   typedef enum logic [1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_ROTATION     = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ROT_NONE = 2'd0,
      ROT_90   = 2'd1,
      ROT_180  = 2'd2,
      ROT_270  = 2'd3
   } rot_mode_type;

   // clamped frame geometry, recomputed from the config registers
   typedef struct packed {
      logic [DIM_W-1:0] w;
      logic [DIM_W-1:0] h;
      logic [POS_W-1:0] ysize;
      logic [POS_W-1:0] ycsize;
      logic [POS_W-1:0] fsize;
   } sizes_type;

   // one sample on its way from the input to the frame store
   typedef struct packed {
      logic [PIX_W-1:0]  pixel;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_bank;
      logic              rd_zero;
      logic              chroma;
      logic [1:0]        plane;
      logic              last;
      logic              outv;
      logic [OFF_W-1:0]  q;
      logic [OFF_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
      logic [POS_W-1:0]  prod;
      logic [POS_W-1:0]  term;
      logic [ADDR_W-1:0] rd_base;
      logic [ADDR_W-1:0] rd_addr;
   } pipe_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] c;
      c = v;
      if (v < MIN_DIM) c = MIN_DIM;
      if (v > maxv) c = maxv;
      return {c[DIM_W-1:1], 1'b0};
   endfunction

endpackage

// File: hw/rtl/yfr_frame_ctrl.sv
// Config registers, frame geometry and write/read position tracking.
// Produces the first pipeline stage of each accepted sample. Uses yfr_pkg.
`timescale 1ns / 1ps

module yfr_frame_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [yfr_pkg::PIX_W-1:0]  req_tdata,
   input  logic                       req_tuser,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [yfr_pkg::DIM_W-1:0]  csr_wdata,
   input  logic                       adv,
   output logic                       st_valid,
   output yfr_pkg::pipe_type          st,
   output yfr_pkg::sizes_type         sizes,
   output yfr_pkg::rot_mode_type      mode
);
   import yfr_pkg::*;

   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   rot_mode_type     mode_ff, mode_in;
   logic             settle_ff, settle_in;
   sizes_type        sizes_ff, sizes_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             bank_ff, bank_in, done_ff, done_in;
   logic             st_valid_ff, st_valid_in;
   pipe_type         st_ff, st_in;

   logic             csr_wr, accept, ovf, wrap;
   logic [POS_W-1:0] p, p_inc;
   logic [DIM_W-1:0] cw, ch;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   // after a config write the input is held off while the geometry registers catch up
   assign req_tready = adv && !settle_ff;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      mode_in   = mode_ff;
      if (csr_wr) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: height_in = csr_wdata;
            CSR_ROTATION:     mode_in   = rot_mode_type'(csr_wdata[1:0]);
            default: ;
         endcase
      end
      settle_in = csr_wr;
   end

   always_comb begin
      cw             = clamp_dim(width_ff, MAX_W_DIM);
      ch             = clamp_dim(height_ff, MAX_H_DIM);
      sizes_in.w     = cw;
      sizes_in.h     = ch;
      sizes_in.ysize = POS_W'(cw) * POS_W'(ch);
      // both dimensions are even, so each chroma plane is a quarter of luma
      sizes_in.ycsize = sizes_in.ysize + (sizes_in.ysize >> 2);
      sizes_in.fsize  = sizes_in.ysize + (sizes_in.ysize >> 1);
   end

   assign p     = req_tuser ? '0 : pos_ff;
   assign p_inc = p + POS_W'(1);
   assign ovf   = (p >= sizes_ff.fsize);
   assign wrap  = (p_inc >= sizes_ff.fsize);

   always_comb begin
      pos_in  = pos_ff;
      bank_in = bank_ff;
      done_in = done_ff;
      if (accept) begin
         if (wrap) begin
            pos_in  = '0;
            bank_in = ~bank_ff;
            done_in = 1'b1;
         end else begin
            pos_in = p_inc;
         end
      end
      st_valid_in = adv ? accept : st_valid_ff;
   end

   always_comb begin
      st_in         = '0;
      st_in.pixel   = req_tdata;
      st_in.wr_addr = bank_ff ? (ADDR_W'(p) + BANK_OFFSET) : ADDR_W'(p);
      st_in.rd_bank = ~bank_ff;
      st_in.outv    = done_ff | wrap;
      if (!done_ff) begin
         st_in.rd_zero = 1'b1;
         st_in.plane   = PLANE_Y;
      end else if (ovf) begin
         // size shrank below the current position: frame ends here
         st_in.rd_zero = 1'b1;
         st_in.plane   = PLANE_V;
         st_in.last    = 1'b1;
      end else begin
         st_in.last = (p_inc == sizes_ff.fsize);
         if (p < sizes_ff.ysize) begin
            st_in.plane = PLANE_Y;
            st_in.q     = OFF_W'(p);
         end else if (p < sizes_ff.ycsize) begin
            st_in.plane  = PLANE_U;
            st_in.chroma = 1'b1;
            st_in.q      = OFF_W'(p - sizes_ff.ysize);
         end else begin
            st_in.plane  = PLANE_V;
            st_in.chroma = 1'b1;
            st_in.q      = OFF_W'(p - sizes_ff.ycsize);
         end
      end
      st_in.rem = st_in.q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= MAX_W_DIM;
         height_ff   <= MAX_H_DIM;
         mode_ff     <= ROT_NONE;
         settle_ff   <= 1'b1;
         pos_ff      <= '0;
         bank_ff     <= 1'b0;
         done_ff     <= 1'b0;
         st_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         mode_ff     <= mode_in;
         settle_ff   <= settle_in;
         pos_ff      <= pos_in;
         bank_ff     <= bank_in;
         done_ff     <= done_in;
         st_valid_ff <= st_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sizes_ff <= sizes_in;
      if (adv) st_ff <= st_in;
   end

   assign st_valid = st_valid_ff;
   assign st       = st_ff;
   assign sizes    = sizes_ff;
   assign mode     = mode_ff;

endmodule

// File: hw/rtl/yfr_addr_gen.sv
// Source address pipeline: restoring divider (one quotient bit per stage)
// splits the output index into row/column, then multiply and add. Uses yfr_pkg.
`timescale 1ns / 1ps

module yfr_addr_gen (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  yfr_pkg::pipe_type     in_stage,
   input  yfr_pkg::sizes_type    sizes,
   input  yfr_pkg::rot_mode_type mode,
   output logic                  out_valid,
   output yfr_pkg::pipe_type     out_stage
);
   import yfr_pkg::*;

   pipe_type         div_src [QUO_W];
   pipe_type         div_in  [QUO_W];
   pipe_type         div_ff  [QUO_W];
   logic [QUO_W-1:0] div_valid_ff;
   pipe_type         mul_ff, mul_in;
   logic             mul_valid_ff;
   pipe_type         adr_ff, adr_in;
   logic             adr_valid_ff;

   // divide the plane-local index by the plane height
   always_comb begin
      logic [POS_W-1:0] trial;
      logic [DIM_W-1:0] sh;
      div_src[0] = in_stage;
      for (int k = 1; k < QUO_W; k++) div_src[k] = div_ff[k-1];
      for (int k = 0; k < QUO_W; k++) begin
         div_in[k] = div_src[k];
         sh        = div_src[k].chroma ? (sizes.h >> 1) : sizes.h;
         trial     = POS_W'(sh) << (QUO_W - 1 - k);
         if ({1'b0, div_src[k].rem} >= trial) begin
            div_in[k].rem               = div_src[k].rem - trial[OFF_W-1:0];
            div_in[k].quo[QUO_W-1-k]    = 1'b1;
         end
      end
   end

   always_comb begin
      pipe_type         s;
      logic [DIM_W-1:0] sw, sh, fac;
      logic [COL_W-1:0] col;
      logic [QUO_W-1:0] row;
      logic [POS_W-1:0] base;
      s      = div_ff[QUO_W-1];
      mul_in = s;
      sw     = s.chroma ? (sizes.w >> 1) : sizes.w;
      sh     = s.chroma ? (sizes.h >> 1) : sizes.h;
      col    = s.rem[COL_W-1:0];
      row    = s.quo;
      case (mode)
         ROT_90: begin
            fac         = sh - DIM_W'(col) - DIM_W'(1);
            mul_in.term = POS_W'(row);
         end
         ROT_180: begin
            fac         = sh;
            mul_in.term = ~POS_W'(s.q);  // adds as -q-1
         end
         ROT_270: begin
            fac         = DIM_W'(col);
            mul_in.term = POS_W'(sw) - POS_W'(row) - POS_W'(1);
         end
         default: begin
            fac         = '0;
            mul_in.term = POS_W'(s.q);
         end
      endcase
      mul_in.prod = POS_W'(fac) * POS_W'(sw);
      case (s.plane)
         PLANE_U: base = sizes.ysize;
         PLANE_V: base = sizes.ycsize;
         default: base = '0;
      endcase
      mul_in.rd_base = s.rd_bank ? (ADDR_W'(base) + BANK_OFFSET) : ADDR_W'(base);
   end

   always_comb begin
      logic [POS_W-1:0] off;
      adr_in         = mul_ff;
      off            = mul_ff.prod + mul_ff.term;
      adr_in.rd_addr = mul_ff.rd_base + ADDR_W'(off);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_valid_ff <= '0;
         mul_valid_ff <= 1'b0;
         adr_valid_ff <= 1'b0;
      end else if (adv) begin
         div_valid_ff <= {div_valid_ff[QUO_W-2:0], in_valid};
         mul_valid_ff <= div_valid_ff[QUO_W-1];
         adr_valid_ff <= mul_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < QUO_W; k++) div_ff[k] <= div_in[k];
         mul_ff <= mul_in;
         adr_ff <= adr_in;
      end
   end

   assign out_valid = adr_valid_ff;
   assign out_stage = adr_ff;

endmodule

// File: hw/rtl/yfr_frame_mem.sv
// Ping-pong frame store (two banks in one array) and the result register.
// Read of the old bank and write of the new bank share one transfer. Uses yfr_pkg.
`timescale 1ns / 1ps

module yfr_frame_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  yfr_pkg::pipe_type         in_stage,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [yfr_pkg::PIX_W-1:0] rsp_tdata,
   output logic [2:0]                rsp_tuser,
   output logic                      rsp_tlast
);
   import yfr_pkg::*;

   logic [PIX_W-1:0] store [STORE_DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic             valid_ff, valid_in;
   logic             zero_ff, outv_ff, last_ff;
   logic [1:0]       plane_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         store[in_stage.wr_addr] <= in_stage.pixel;
         rd_data_ff              <= store[in_stage.rd_addr];
         zero_ff                 <= in_stage.rd_zero;
         outv_ff                 <= in_stage.outv;
         plane_ff                <= in_stage.plane;
         last_ff                 <= in_stage.last;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (load) valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = zero_ff ? '0 : rd_data_ff;
   assign rsp_tuser  = {plane_ff, outv_ff};
   assign rsp_tlast  = last_ff;

endmodule

// File: hw/rtl/yuv420_frame_rotator.sv
// Top level of the YUV 4:2:0 frame rotator.
// Instantiates yfr_frame_ctrl, yfr_addr_gen and yfr_frame_mem; uses yfr_pkg.
`timescale 1ns / 1ps

// Usage:
//   req_*  : source samples in raster order, Y plane then U then V. One
//            transfer per sample; req_tuser flags the first luma sample of a
//            frame and restarts the position counters.
//   rsp_*  : exactly one result per input sample: a sample of the previous
//            frame, rotated by 0/90/180/270 degrees, in output raster order.
//            rsp_tuser[0] is low until a first full frame has been stored.
//   csr_*  : register writes (0 width, 1 height, 2 rotation), always ready;
//            write only while no samples are in flight. The input stalls
//            after each write while frame geometry is recomputed.
// Throughput is one sample per clock while results are taken and no register
// write stalls the input. Twelve register stages: one position stage loaded
// by the input transfer, eight divider stages (one row bit each), one multiply,
// one address add, and the store read into the result register. The store has
// one write and one read port; the read hits the opposite bank of the write, so
// no forwarding is needed.
// Reset clears counters, flags and config (256x256, no rotation); store contents
// stay undefined. When the receiver stalls, the pipeline keeps filling bubbles
// ahead of the result register and only stops the input once a sample waits at its end.

module yuv420_frame_rotator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [yfr_pkg::PIX_W-1:0] req_tdata,   // [7:0] pixel_in
   input  logic                      req_tuser,   // [0] frame_start
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [yfr_pkg::PIX_W-1:0] rsp_tdata,   // [7:0] pixel_out
   output logic [2:0]                rsp_tuser,   // [0] out_valid, [2:1] plane_index
   output logic                      rsp_tlast,   // frame_last
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [yfr_pkg::DIM_W-1:0] csr_wdata
);
   import yfr_pkg::*;

   logic         adv, load;
   logic         st_valid, pre_valid;
   pipe_type     st, pre;
   sizes_type    sizes;
   rot_mode_type mode;

   // the pipeline moves unless a finished sample is blocked at the output
   assign load = pre_valid && (!rsp_tvalid || rsp_tready);
   assign adv  = !pre_valid || !rsp_tvalid || rsp_tready;

   yfr_frame_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .adv        (adv),
      .st_valid   (st_valid),
      .st         (st),
      .sizes      (sizes),
      .mode       (mode)
   );

   yfr_addr_gen u_addr (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (st_valid),
      .in_stage  (st),
      .sizes     (sizes),
      .mode      (mode),
      .out_valid (pre_valid),
      .out_stage (pre)
   );

   yfr_frame_mem u_mem (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .in_stage   (pre),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: hw/rtl/yfr_checker.sv
// Port-level checks for the frame rotator result channel, bound to the top.
// Depends on yfr_pkg and yuv420_frame_rotator.
`timescale 1ns / 1ps

module yfr_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [yfr_pkg::PIX_W-1:0] rsp_tdata,
   input logic [2:0]                rsp_tuser,
   input logic                      rsp_tlast
);
   import yfr_pkg::*;

   // stalled result stays offered
   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser)
                                    && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // before the first stored frame every field is zero
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0 && rsp_tuser[2:1] == PLANE_Y
                                      && !rsp_tlast)
      else $error("fields not cleared on invalid output");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("frame end flagged on invalid output");

   a_plane_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2:1] == PLANE_Y || rsp_tuser[2:1] == PLANE_U
                     || rsp_tuser[2:1] == PLANE_V)
      else $error("bad plane code");

endmodule

bind yuv420_frame_rotator yfr_checker u_yfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: verif/tb.sv
// Self-checking bench for yuv420_frame_rotator: streams planar 4:2:0 frames,
// predicts every rotated output sample from a local frame-store mirror and
// compares it field by field. Depends on yfr_pkg and the rotator RTL only.
`timescale 1ns / 1ps

module tb;
   import yfr_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             fstart;
   } sample_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic             outv;
      logic [1:0]       plane;
      logic             last;
   } rot_result_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [PIX_W-1:0] req_tdata = '0;
   logic             req_tuser = 1'b0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [PIX_W-1:0] rsp_tdata;
   logic [2:0]       rsp_tuser;
   logic             rsp_tlast;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = CSR_FRAME_WIDTH;
   logic [DIM_W-1:0] csr_wdata = '0;

   yuv420_frame_rotator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------- mirror
   logic [PIX_W-1:0] store_mirror [STORE_DEPTH];
   int               wr_pos = 0;
   int               rd_pos = 0;
   logic             bank_wr = 1'b0;
   logic             have_frame = 1'b0;
   logic [DIM_W-1:0] cfg_w = DIM_W'(256);
   logic [DIM_W-1:0] cfg_h = DIM_W'(256);
   rot_mode_type     cfg_rot = ROT_NONE;

   sample_type       sample_q[$];
   rot_result_type   rotated_q[$];
   int               in_count = 0;
   int               sent_count = 0;
   int               fail_count = 0;
   logic             hold_rsp = 1'b0;

   function automatic int fit_dim(logic [DIM_W-1:0] raw, int top);
      int v;
      v = raw;
      if (v < 2) v = 2;
      if (v > top) v = top;
      return v - (v % 2);
   endfunction

   function automatic int frame_size();
      int w, h;
      w = fit_dim(cfg_w, MAX_WIDTH);
      h = fit_dim(cfg_h, MAX_HEIGHT);
      return w * h + 2 * (w / 2) * (h / 2);
   endfunction

   // source offset inside a sw x sh plane for output raster offset p
   function automatic int src_index(int p, int sw, int sh);
      int row, col;
      row = p / sh;
      col = p % sh;
      case (cfg_rot)
         ROT_90:  return (sh - col - 1) * sw + row;
         ROT_180: return sw * sh - 1 - p;
         ROT_270: return col * sw + (sw - row - 1);
         default: return p;
      endcase
   endfunction

   task automatic rotate_step(input sample_type s);
      int w, h, ysize, csize, fsize, src, rbase, wbase;
      rot_result_type r;
      w = fit_dim(cfg_w, MAX_WIDTH);
      h = fit_dim(cfg_h, MAX_HEIGHT);
      ysize = w * h;
      csize = (w / 2) * (h / 2);
      fsize = frame_size();
      wbase = bank_wr ? BANK_SIZE : 0;
      rbase = bank_wr ? 0 : BANK_SIZE;
      r = '0;
      if (s.fstart) begin
         wr_pos = 0;
         rd_pos = 0;
      end
      if (have_frame) begin
         // frame shrunk under a running frame: reader is already past the end
         if (rd_pos >= fsize) begin
            r.plane = PLANE_V;
            r.last  = 1'b1;
         end else begin
            if (rd_pos < ysize) begin
               r.plane = PLANE_Y;
               src = src_index(rd_pos, w, h);
            end else if (rd_pos < ysize + csize) begin
               r.plane = PLANE_U;
               src = ysize + src_index(rd_pos - ysize, w / 2, h / 2);
            end else begin
               r.plane = PLANE_V;
               src = ysize + csize + src_index(rd_pos - ysize - csize, w / 2, h / 2);
            end
            r.pixel = store_mirror[rbase + src];
            r.last  = (rd_pos == fsize - 1);
         end
      end
      if (wr_pos < BANK_SIZE) store_mirror[wbase + wr_pos] = s.pixel;
      if (wr_pos + 1 >= fsize) begin
         wr_pos = 0;
         rd_pos = 0;
         bank_wr = ~bank_wr;
         have_frame = 1'b1;
      end else begin
         wr_pos++;
         rd_pos++;
      end
      r.outv = have_frame;
      rotated_q.push_back(r);
   endtask

   // mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm = calm - 1;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(20, 120);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------- driver
   int         req_gap = 0;
   int         req_calm = 0;
   sample_type nxt;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rotate_step('{pixel: req_tdata, fstart: req_tuser});
            in_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_tvalid <= 1'b0;
            end else if (sample_q.size() > 0) begin
               nxt = sample_q.pop_front();
               req_tdata  <= nxt.pixel;
               req_tuser  <= nxt.fstart;
               req_tvalid <= 1'b1;
               req_gap = pick_gap(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------- monitor
   int             rsp_gap = 0;
   int             rsp_calm = 0;
   rot_result_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (rotated_q.size() == 0) begin
               $error("unexpected transfer: pixel_out %0d", rsp_tdata);
               fail_count++;
            end else begin
               want = rotated_q.pop_front();
               if (rsp_tdata !== want.pixel) begin
                  $error("pixel_out: expected %0d, got %0d", want.pixel, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tuser[0] !== want.outv) begin
                  $error("out_valid: expected %0d, got %0d", want.outv, rsp_tuser[0]);
                  fail_count++;
               end
               if (rsp_tuser[2:1] !== want.plane) begin
                  $error("plane_index: expected %0d, got %0d", want.plane, rsp_tuser[2:1]);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("frame_last: expected %0d, got %0d", want.last, rsp_tlast);
                  fail_count++;
               end
            end
            rsp_gap = pick_gap(rsp_calm);
         end else if (rsp_gap > 0) begin
            rsp_gap--;
         end
         rsp_tready <= !hold_rsp && rsp_gap == 0;
      end
   end

   // long receiver hold-off while the sender keeps streaming
   initial begin
      wait (in_count >= 1000);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      #8_000_000;
      $display("simulation failed");
      $finish;
   end

   // -------------------------------------------------------------- stimulus
   // valid stays up across back-to-back writes; csr_done drops it afterwards
   task automatic csr_write(csr_index_type idx, logic [DIM_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_FRAME_WIDTH:  cfg_w = val;
         CSR_FRAME_HEIGHT: cfg_h = val;
         CSR_ROTATION:     cfg_rot = rot_mode_type'(val[1:0]);
         default: ;
      endcase
   endtask

   task automatic csr_done();
      csr_valid <= 1'b0;
   endtask

   // every queued sample accepted and every result transferred
   task automatic drain();
      while (in_count != sent_count || rotated_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic push_frame(int n, bit with_start);
      sample_type s;
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 15);
         s.pixel  = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : PIX_W'($urandom_range(0, 255));
         s.fstart = with_start && i == 0;
         sample_q.push_back(s);
         sent_count++;
      end
   endtask

   // out-of-range and odd codes that clamp to the wanted even size
   function automatic logic [DIM_W-1:0] dim_code(int target);
      case ($urandom_range(0, 3))
         0: return DIM_W'(target + 1);
         1: begin
            if (target == 2) return DIM_W'($urandom_range(0, 1));
            if (target == 256) return DIM_W'($urandom_range(257, 511));
            return DIM_W'(target);
         end
         default: return DIM_W'(target);
      endcase
   endfunction

   initial begin : stimulus
      int rand_items, nfr, fs, len, r, tw, th;
      rand_items = 0;
      while (reset) @(posedge clock);

      // both banks get a full 768-sample frame first, so every later size
      // (at most 768 samples) only reads stored entries
      csr_write(CSR_FRAME_WIDTH, DIM_W'(511));
      csr_write(CSR_FRAME_HEIGHT, DIM_W'(1));
      csr_write(CSR_ROTATION, DIM_W'(ROT_NONE));
      csr_done();
      push_frame(5, 1'b1);            // first frame restarted, output invalid
      push_frame(frame_size(), 1'b1);
      drain();
      csr_write(CSR_ROTATION, DIM_W'(ROT_90));
      csr_done();
      push_frame(frame_size(), 1'b1);
      drain();

      // tall narrow plane at 270, cut short by the next frame start
      csr_write(CSR_FRAME_WIDTH, DIM_W'(0));
      csr_write(CSR_FRAME_HEIGHT, DIM_W'(300));
      csr_write(CSR_ROTATION, DIM_W'(ROT_270));
      csr_done();
      push_frame(6, 1'b1);
      drain();

      // shrink under a running frame, then a 180 flip of a tiny frame
      csr_write(CSR_FRAME_WIDTH, DIM_W'(5));
      csr_write(CSR_FRAME_HEIGHT, DIM_W'(4));
      csr_write(CSR_ROTATION, DIM_W'(ROT_180));
      csr_done();
      push_frame(20, 1'b1);
      drain();
      csr_write(CSR_FRAME_WIDTH, DIM_W'(2));
      csr_write(CSR_FRAME_HEIGHT, DIM_W'(3));
      csr_done();
      push_frame(1, 1'b0);
      push_frame(6, 1'b0);
      drain();

      while (rand_items < 300) begin
         if ($urandom_range(0, 2) != 0) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
               tw = 256;
               th = 2;
            end else if (r == 1) begin
               tw = 2;
               th = 256;
            end else begin
               tw = 2 * $urandom_range(1, $urandom_range(1, 8));
               th = 2 * $urandom_range(1, $urandom_range(1, 8));
            end
            csr_write(CSR_FRAME_WIDTH, dim_code(tw));
            csr_write(CSR_FRAME_HEIGHT, dim_code(th));
         end
         if ($urandom_range(0, 1) != 0)
            csr_write(CSR_ROTATION, DIM_W'($urandom_range(0, 3)));
         csr_done();

         nfr = $urandom_range(1, 3);
         for (int f = 0; f < nfr; f++) begin
            fs = frame_size();
            len = fs;
            // big frames are mostly cut short to keep the run brief
            if ((fs > 400) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0))
               len = $urandom_range(1, (fs > 150) ? 150 : fs - 1);
            push_frame(len, $urandom_range(0, 9) != 0);
            rand_items += len;
         end
         drain();
      end

      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
